// File: hw/rtl/brop_pkg.sv
// Shared types and constants for the BOOTP reply option parser.
// Used by the byte parser, the record queue and the top level.
package brop_pkg;

  localparam int KIND_W  = 4;
  localparam int VALUE_W = 32;
  localparam int QDEPTH  = 4;

  typedef enum logic [KIND_W-1:0] {
    KIND_YOUR_IP   = 4'd0,
    KIND_SERVER    = 4'd1,
    KIND_RELAY     = 4'd2,
    KIND_MASK      = 4'd3,
    KIND_TIME_OFFS = 4'd4,
    KIND_ROUTER    = 4'd5,
    KIND_TIME_SRV  = 4'd6,
    KIND_DNS       = 4'd7,
    KIND_LOG       = 4'd8,
    KIND_LPR       = 4'd9,
    KIND_SWAP      = 4'd10,
    KIND_BOOT_SIZE = 4'd11,
    KIND_HOST_CHAR = 4'd12,
    KIND_DOM_CHAR  = 4'd13,
    KIND_FILE_CHAR = 4'd14,
    KIND_END       = 4'd15
  } rec_kind_t;

  typedef struct packed {
    rec_kind_t          kind;
    logic [VALUE_W-1:0] value;
    logic               done;
  } brop_rec_t;

  typedef struct packed {
    brop_rec_t  rec0;
    brop_rec_t  rec1;
    logic [1:0] count;
  } brop_push_t;

  localparam logic [7:0] COOKIE [4] = '{8'h63, 8'h82, 8'h53, 8'h63};

  localparam logic [7:0] BOOTREPLY  = 8'd2;
  localparam logic [7:0] TAG_PAD    = 8'd0;
  localparam logic [7:0] TAG_MASK   = 8'd1;
  localparam logic [7:0] TAG_TOFFS  = 8'd2;
  localparam logic [7:0] TAG_ROUTER = 8'd3;
  localparam logic [7:0] TAG_TSRV   = 8'd4;
  localparam logic [7:0] TAG_DNS    = 8'd6;
  localparam logic [7:0] TAG_LOG    = 8'd7;
  localparam logic [7:0] TAG_LPR    = 8'd9;
  localparam logic [7:0] TAG_HOST   = 8'd12;
  localparam logic [7:0] TAG_BSIZE  = 8'd13;
  localparam logic [7:0] TAG_DOMAIN = 8'd15;
  localparam logic [7:0] TAG_SWAP   = 8'd16;
  localparam logic [7:0] TAG_END    = 8'd255;

endpackage

// File: hw/rtl/brop_parse.sv
// Byte parser of the BOOTP reply: header checks, address and file name
// fields, and the vendor option walk. Depends on brop_pkg.
module brop_parse #(
  parameter int MAX_MESSAGE_BYTES = 2048,
  parameter int NAME_LIMIT        = 63
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  logic [7:0]          msg_byte,
  input  logic                msg_last,
  input  logic [31:0]         xid,
  output brop_pkg::brop_push_t push
);
  import brop_pkg::*;

  localparam int OFF_W = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam logic [OFF_W-1:0] OFF_MAX = OFF_W'(MAX_MESSAGE_BYTES);
  localparam logic [7:0] NAME_MAX = 8'(NAME_LIMIT);

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OP    = 2'd1;
  localparam logic [1:0] ST_XID   = 2'd2;
  localparam logic [1:0] ST_SHORT = 2'd3;

  typedef enum logic [1:0] {PH_TAG, PH_LEN, PH_DATA, PH_DONE} phase_t;

  logic [OFF_W-1:0] off_r, off_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [31:0]      shift_r, shift_nxt;
  phase_t           phase_r, phase_nxt;
  logic [7:0]       tag_r, tag_nxt;
  logic [7:0]       rem_r, rem_nxt;
  logic [7:0]       len_r, len_nxt;
  logic             cookie_r, cookie_nxt;
  logic             stop_r, stop_nxt;
  logic [7:0]       cnt_r, cnt_nxt;

  logic [31:0]      sh_new;
  logic [7:0]       idx;
  logic [7:0]       rem_dec;
  logic [7:0]       want;
  logic             list_vld;
  rec_kind_t        list_kind;
  logic             data_vld;
  brop_rec_t        data_rec;
  brop_rec_t        end_rec;
  logic [1:0]       st_fin;

  assign sh_new  = {shift_r[23:0], msg_byte};
  assign idx     = len_r - rem_r;
  assign rem_dec = rem_r - 8'd1;

  always_comb begin
    unique case (off_r[1:0])
      2'd0: want = xid[31:24];
      2'd1: want = xid[23:16];
      2'd2: want = xid[15:8];
      default: want = xid[7:0];
    endcase
  end

  always_comb begin
    list_vld  = 1'b1;
    list_kind = KIND_ROUTER;
    unique case (tag_r)
      TAG_TOFFS:  list_kind = KIND_TIME_OFFS;
      TAG_ROUTER: list_kind = KIND_ROUTER;
      TAG_TSRV:   list_kind = KIND_TIME_SRV;
      TAG_DNS:    list_kind = KIND_DNS;
      TAG_LOG:    list_kind = KIND_LOG;
      TAG_LPR:    list_kind = KIND_LPR;
      TAG_SWAP:   list_kind = KIND_SWAP;
      default:    list_vld  = 1'b0;
    endcase
  end

  always_comb begin
    off_nxt    = off_r;
    status_nxt = status_r;
    shift_nxt  = shift_r;
    phase_nxt  = phase_r;
    tag_nxt    = tag_r;
    rem_nxt    = rem_r;
    len_nxt    = len_r;
    cookie_nxt = cookie_r;
    stop_nxt   = stop_r;
    cnt_nxt    = cnt_r;
    data_vld   = 1'b0;
    data_rec   = '{kind: KIND_YOUR_IP, value: sh_new, done: 1'b0};

    if (off_r < OFF_MAX) begin
      off_nxt = off_r + OFF_W'(1);
      if (off_r == OFF_W'(0)) begin
        if (msg_byte != BOOTREPLY) status_nxt = ST_OP;
      end else if (off_r >= OFF_W'(4) && off_r <= OFF_W'(7)) begin
        if (status_r == ST_OK && msg_byte != want) status_nxt = ST_XID;
      end else if (status_r == ST_OK && off_r >= OFF_W'(8)) begin
        if (off_r >= OFF_W'(16) && off_r <= OFF_W'(27)) begin
          shift_nxt = sh_new;
          if (off_r == OFF_W'(19)) begin
            data_vld = 1'b1;
          end else if (off_r == OFF_W'(23)) begin
            data_vld      = 1'b1;
            data_rec.kind = KIND_SERVER;
          end else if (off_r == OFF_W'(27)) begin
            data_vld      = 1'b1;
            data_rec.kind = KIND_RELAY;
          end
        end else if (off_r >= OFF_W'(108) && off_r <= OFF_W'(235)) begin
          if (!stop_r) begin
            if (msg_byte == 8'd0) begin
              stop_nxt = 1'b1;
            end else begin
              data_vld = 1'b1;
              data_rec = '{kind: KIND_FILE_CHAR, value: 32'(msg_byte), done: 1'b0};
            end
          end
        end else if (off_r >= OFF_W'(236) && off_r <= OFF_W'(239)) begin
          if (off_r[1:0] == 2'd0) cookie_nxt = (msg_byte == COOKIE[0]);
          else cookie_nxt = cookie_r & (msg_byte == COOKIE[off_r[1:0]]);
        end else if (off_r >= OFF_W'(240) && cookie_r) begin
          unique case (phase_r)
            PH_TAG: begin
              if (msg_byte == TAG_END) begin
                phase_nxt = PH_DONE;
              end else if (msg_byte != TAG_PAD) begin
                tag_nxt   = msg_byte;
                phase_nxt = PH_LEN;
              end
            end
            PH_LEN: begin
              len_nxt   = msg_byte;
              rem_nxt   = msg_byte;
              shift_nxt = '0;
              cnt_nxt   = '0;
              stop_nxt  = 1'b0;
              phase_nxt = (msg_byte == 8'd0) ? PH_TAG : PH_DATA;
            end
            PH_DATA: begin
              shift_nxt = sh_new;
              if (tag_r == TAG_HOST || tag_r == TAG_DOMAIN) begin
                if (msg_byte == 8'd0) begin
                  stop_nxt = 1'b1;
                end else if (!stop_r && cnt_r < NAME_MAX) begin
                  data_vld = 1'b1;
                  data_rec = '{kind: (tag_r == TAG_HOST) ? KIND_HOST_CHAR : KIND_DOM_CHAR,
                               value: 32'(msg_byte), done: 1'b0};
                  cnt_nxt  = cnt_r + 8'd1;
                end
              end else if (tag_r == TAG_MASK) begin
                if (len_r == 8'd4 && idx == 8'd3) begin
                  data_vld      = 1'b1;
                  data_rec.kind = KIND_MASK;
                end
              end else if (tag_r == TAG_BSIZE) begin
                if (len_r == 8'd2 && idx == 8'd1) begin
                  data_vld = 1'b1;
                  data_rec = '{kind: KIND_BOOT_SIZE, value: {7'd0, sh_new[15:0], 9'd0},
                               done: 1'b0};
                end
              end else if (list_vld && len_r >= 8'd4 && idx == 8'd3) begin
                data_vld      = 1'b1;
                data_rec.kind = list_kind;
              end
              rem_nxt = rem_dec;
              if (rem_dec == 8'd0) phase_nxt = PH_TAG;
            end
            default: ;
          endcase
        end
      end
    end
  end

  assign st_fin  = (status_nxt == ST_OK && off_nxt < OFF_W'(8)) ? ST_SHORT : status_nxt;
  assign end_rec = '{kind: KIND_END, value: {29'd0, cookie_nxt, st_fin}, done: 1'b1};

  always_comb begin
    push = '{rec0: end_rec, rec1: end_rec, count: 2'd0};
    if (acc) begin
      if (data_vld) begin
        push.rec0  = data_rec;
        push.count = msg_last ? 2'd2 : 2'd1;
      end else if (msg_last) begin
        push.count = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (acc && msg_last)) begin
      off_r    <= '0;
      status_r <= ST_OK;
      shift_r  <= '0;
      phase_r  <= PH_TAG;
      tag_r    <= '0;
      rem_r    <= '0;
      len_r    <= '0;
      cookie_r <= 1'b0;
      stop_r   <= 1'b0;
      cnt_r    <= '0;
    end else if (acc) begin
      off_r    <= off_nxt;
      status_r <= status_nxt;
      shift_r  <= shift_nxt;
      phase_r  <= phase_nxt;
      tag_r    <= tag_nxt;
      rem_r    <= rem_nxt;
      len_r    <= len_nxt;
      cookie_r <= cookie_nxt;
      stop_r   <= stop_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && msg_last |=> off_r == '0 && status_r == ST_OK)
    else $error("Message state was not cleared after the last byte.");

  a_reject_silent: assert property (@(posedge clk) disable iff (!rst_n)
    acc && status_r != ST_OK |-> !data_vld)
    else $error("A rejected message produced a data record.");

  a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
    acc && phase_r == PH_DONE && off_r >= OFF_W'(240) |-> !data_vld)
    else $error("An option record followed the end option.");

endmodule

// File: hw/rtl/brop_rec_fifo.sv
// Four-entry record queue that takes up to two records and gives one per cycle while pop is high.
// Depends on brop_pkg.
module brop_rec_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  brop_pkg::brop_push_t push,
  input  logic                 pop,
  output brop_pkg::brop_rec_t  head,
  output logic                 head_vld,
  output logic                 room2
);
  import brop_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);

  brop_rec_t        mem_r [QDEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [PTR_W:0]   cnt_r, cnt_nxt;

  assign head     = mem_r[rd_r];
  assign head_vld = (cnt_r != '0);
  assign room2    = (cnt_r <= (PTR_W + 1)'(QDEPTH - 2));
  assign cnt_nxt  = cnt_r + (PTR_W + 1)'(push.count) - (PTR_W + 1)'(pop && head_vld);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem_r[wr_r] <= push.rec0;
    if (push.count == 2'd2) mem_r[wr_r + PTR_W'(1)] <= push.rec1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + PTR_W'(push.count);
      if (pop && head_vld) rd_r <= rd_r + PTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: hw/rtl/bootp_reply_option_parser.sv
// A record is written into the queue when its byte is accepted and is offered on
// out_tvalid at the queue head. Throughput: one byte per cycle; a byte gives at most
// two records, which leave one per cycle while out_tready is high, through a
// four-entry queue that holds in_tready low when it has fewer than two free entries.
// Reset (rst_n low at a clock edge) clears the message state, the queue and the
// expected transaction id.
module bootp_reply_option_parser #(
  parameter int MAX_MESSAGE_BYTES = 2048,
  parameter int NAME_LIMIT        = 63
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [31:0]                   cfg_wr_data,  // expected_transaction_id
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,     // message_byte
  input  logic                          in_tlast,     // final_byte
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [brop_pkg::VALUE_W-1:0]  out_tdata,    // record_value
  output logic [brop_pkg::KIND_W-1:0]   out_tuser,    // record_kind
  output logic                          out_tlast     // message_done
);
  import brop_pkg::*;

  logic        xid_r;
  logic [31:0] xid_val_r;
  logic        in_acc;
  brop_push_t  push;
  brop_rec_t   head;
  logic        room2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xid_val_r <= '0;
      xid_r     <= 1'b0;
    end else if (cfg_wr_en) begin
      xid_val_r <= cfg_wr_data;
      xid_r     <= 1'b1;
    end
  end

  assign in_tready = room2;
  assign in_acc    = in_tvalid && in_tready;

  brop_parse #(
    .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES),
    .NAME_LIMIT       (NAME_LIMIT)
  ) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (in_acc),
    .msg_byte(in_tdata),
    .msg_last(in_tlast),
    .xid     (xid_val_r),
    .push    (push)
  );

  brop_rec_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .pop     (out_tready),
    .head    (head),
    .head_vld(out_tvalid),
    .room2   (room2)
  );

  assign out_tdata = head.value;
  assign out_tuser = head.kind;
  assign out_tlast = head.done;

  a_last_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == KIND_END)
    else $error("A record marked last is not an end record.");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_END |-> out_tlast)
    else $error("An end record is not marked last.");

  a_stall_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("Input stalled while no record was waiting.");

  a_cfg_seen: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> xid_r && xid_val_r == $past(cfg_wr_data))
    else $error("Transaction id write was lost.");

endmodule

// File: tb/tb_bootp_reply_option_parser.sv
// Self-checking testbench for bootp_reply_option_parser: streams BOOTP replies
// byte by byte, rebuilds the expected records in a local parser, and compares them
// with the record stream. Depends on brop_pkg and the parser RTL.
module tb_bootp_reply_option_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import brop_pkg::*;

  localparam int MSG_BYTES_MAX  = 2048;
  localparam int NAME_CHARS_MAX = 63;
  localparam int CYCLE_LIMIT    = 50000;
  localparam int PRINT_MAX      = 50;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_OP  = 2'd1;
  localparam logic [1:0] ST_BAD_XID = 2'd2;
  localparam logic [1:0] ST_SHORT   = 2'd3;

  localparam logic [7:0] TAG_UNKNOWN_A = 8'd200;
  localparam logic [7:0] TAG_UNKNOWN_B = 8'd77;

  typedef enum logic [1:0] {OPT_TAG, OPT_LEN, OPT_DATA, OPT_DONE} opt_phase_t;
  typedef enum {FILL_RANDOM, FILL_TEXT, FILL_ONES, FILL_ZERO} fill_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [VALUE_W-1:0] out_tdata;
  logic [KIND_W-1:0]  out_tuser;
  logic        out_tlast;

  in_item_t    pending_bytes[$];
  brop_rec_t   due_records[$];
  logic [7:0]  msg[$];
  in_item_t    next_byte;
  logic        in_fired = 1'b0;
  int          idle_pct = 11;
  int          queued_count = 0;
  int          accepted_count = 0;
  int          error_count = 0;
  int          cycle_count = 0;

  logic [31:0] xid_model = '0;
  int          msg_off;
  logic [1:0]  status;
  logic [31:0] shift_reg;
  opt_phase_t  opt_phase;
  logic [7:0]  opt_tag;
  logic [7:0]  opt_left;
  logic [7:0]  opt_len;
  logic        cookie_good;
  logic        name_stop;
  logic [7:0]  name_cnt;

  bootp_reply_option_parser uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  always #5 clk = ~clk;

  function automatic void clear_parse();
    msg_off     = 0;
    status      = ST_OK;
    shift_reg   = '0;
    opt_phase   = OPT_TAG;
    opt_tag     = '0;
    opt_left    = '0;
    opt_len     = '0;
    cookie_good = 1'b0;
    name_stop   = 1'b0;
    name_cnt    = '0;
  endfunction

  function automatic void add_record(rec_kind_t kind, logic [31:0] value, logic done);
    brop_rec_t r;
    r.kind  = kind;
    r.value = value;
    r.done  = done;
    due_records.push_back(r);
  endfunction

  function automatic void walk_option(logic [7:0] b);
    logic [7:0] idx;
    rec_kind_t  kind;
    logic       is_list;
    case (opt_phase)
      OPT_TAG: begin
        if (b == TAG_END) begin
          opt_phase = OPT_DONE;
        end else if (b != TAG_PAD) begin
          opt_tag   = b;
          opt_phase = OPT_LEN;
        end
      end
      OPT_LEN: begin
        opt_len   = b;
        opt_left  = b;
        shift_reg = '0;
        name_cnt  = '0;
        name_stop = 1'b0;
        opt_phase = (b == 8'd0) ? OPT_TAG : OPT_DATA;
      end
      OPT_DATA: begin
        idx       = opt_len - opt_left;
        shift_reg = {shift_reg[23:0], b};
        if (opt_tag == TAG_HOST || opt_tag == TAG_DOMAIN) begin
          if (b == 8'd0) begin
            name_stop = 1'b1;
          end else if (!name_stop && name_cnt < NAME_CHARS_MAX) begin
            add_record(opt_tag == TAG_HOST ? KIND_HOST_CHAR : KIND_DOM_CHAR, 32'(b), 1'b0);
            name_cnt++;
          end
        end else if (opt_tag == TAG_MASK) begin
          if (opt_len == 8'd4 && idx == 8'd3) add_record(KIND_MASK, shift_reg, 1'b0);
        end else if (opt_tag == TAG_BSIZE) begin
          if (opt_len == 8'd2 && idx == 8'd1)
            add_record(KIND_BOOT_SIZE, {7'd0, shift_reg[15:0], 9'd0}, 1'b0);
        end else begin
          is_list = 1'b1;
          kind    = KIND_END;
          case (opt_tag)
            TAG_TOFFS:  kind = KIND_TIME_OFFS;
            TAG_ROUTER: kind = KIND_ROUTER;
            TAG_TSRV:   kind = KIND_TIME_SRV;
            TAG_DNS:    kind = KIND_DNS;
            TAG_LOG:    kind = KIND_LOG;
            TAG_LPR:    kind = KIND_LPR;
            TAG_SWAP:   kind = KIND_SWAP;
            default:    is_list = 1'b0;
          endcase
          if (is_list && opt_len >= 8'd4 && idx == 8'd3) add_record(kind, shift_reg, 1'b0);
        end
        opt_left--;
        if (opt_left == 8'd0) opt_phase = OPT_TAG;
      end
      default: ;
    endcase
  endfunction

  function automatic void parse_byte(logic [7:0] b, logic fin);
    logic [1:0] st;
    if (msg_off < MSG_BYTES_MAX) begin
      if (msg_off == 0) begin
        if (b != BOOTREPLY) status = ST_BAD_OP;
      end else if (msg_off >= 4 && msg_off <= 7) begin
        if (status == ST_OK && b != xid_model[8*(7-msg_off) +: 8]) status = ST_BAD_XID;
      end else if (status == ST_OK && msg_off >= 8) begin
        if (msg_off >= 16 && msg_off <= 27) begin
          shift_reg = {shift_reg[23:0], b};
          if (msg_off == 19) add_record(KIND_YOUR_IP, shift_reg, 1'b0);
          else if (msg_off == 23) add_record(KIND_SERVER, shift_reg, 1'b0);
          else if (msg_off == 27) add_record(KIND_RELAY, shift_reg, 1'b0);
        end else if (msg_off >= 108 && msg_off <= 235) begin
          if (!name_stop) begin
            if (b == 8'd0) name_stop = 1'b1;
            else add_record(KIND_FILE_CHAR, 32'(b), 1'b0);
          end
        end else if (msg_off >= 236 && msg_off <= 239) begin
          if (msg_off == 236) cookie_good = (b == COOKIE[0]);
          else cookie_good = cookie_good && (b == COOKIE[msg_off-236]);
        end else if (msg_off >= 240 && cookie_good) begin
          walk_option(b);
        end
      end
      msg_off++;
    end
    if (fin) begin
      st = status;
      if (st == ST_OK && msg_off < 8) st = ST_SHORT;
      add_record(KIND_END, {29'd0, cookie_good, st}, 1'b1);
      clear_parse();
    end
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    if (error_count < PRINT_MAX)
      $display("%0t: record %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
    error_count++;
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= idle_pct);
      if (!in_tvalid || in_fired) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= idle_pct) begin
          next_byte = pending_bytes.pop_front();
          in_tdata  <= next_byte.data;
          in_tlast  <= next_byte.last;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    brop_rec_t want;
    in_fired <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      parse_byte(in_tdata, in_tlast);
      accepted_count++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (due_records.size() == 0) begin
        report_mismatch("without expectation, kind", '0, 32'(out_tuser));
      end else begin
        want = due_records.pop_front();
        if (out_tuser != want.kind) report_mismatch("kind", 32'(want.kind), 32'(out_tuser));
        if (out_tdata != want.value) report_mismatch("value", want.value, out_tdata);
        if (out_tlast != want.done) report_mismatch("done", 32'(want.done), 32'(out_tlast));
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [7:0] fill_byte(fill_t fill);
    case (fill)
      FILL_TEXT: return 8'($urandom_range(1, 255));
      FILL_ONES: return 8'hFF;
      FILL_ZERO: return 8'h00;
      default:   return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic put_header(logic [7:0] op, logic [31:0] xid, int nul_at, fill_t addr_fill);
    msg.push_back(op);
    repeat (3) msg.push_back(fill_byte(FILL_RANDOM));
    for (int i = 3; i >= 0; i--) msg.push_back(xid[8*i +: 8]);
    repeat (8) msg.push_back(fill_byte(FILL_RANDOM));
    repeat (12) msg.push_back(fill_byte(addr_fill));
    repeat (80) msg.push_back(fill_byte(FILL_RANDOM));
    for (int i = 0; i < 128; i++)
      msg.push_back(i == nul_at ? 8'h00 : fill_byte(i < nul_at ? FILL_TEXT : FILL_RANDOM));
  endtask

  task automatic put_cookie(bit good);
    for (int i = 0; i < 4; i++) msg.push_back(COOKIE[i]);
    if (!good) msg[msg.size()-1-$urandom_range(3)] ^= 8'(1 << $urandom_range(7));
  endtask

  task automatic put_option(logic [7:0] tag, int len, fill_t fill);
    msg.push_back(tag);
    msg.push_back(8'(len));
    repeat (len) msg.push_back(fill_byte(fill));
  endtask

  task automatic queue_message(bit close);
    in_item_t it;
    @(posedge clk);
    foreach (msg[i]) begin
      it.data = msg[i];
      it.last = close && (i == msg.size() - 1);
      pending_bytes.push_back(it);
    end
    queued_count += msg.size();
    msg.delete();
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (accepted_count != queued_count || due_records.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_xid(logic [31:0] v);
    @(negedge clk);
    cfg_wr_data = v;
    cfg_wr_en   = 1'b1;
    xid_model   = v;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
  endtask

  initial begin
    clear_parse();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    msg.push_back(8'h01);
    repeat (10) msg.push_back(fill_byte(FILL_RANDOM));
    queue_message(1);
    msg.push_back(BOOTREPLY);
    queue_message(1);
    msg.push_back(8'h00);
    queue_message(1);
    put_header(BOOTREPLY, xid_model, 0, FILL_RANDOM);
    msg = msg[0:6];
    queue_message(1);
    put_header(BOOTREPLY, xid_model, 0, FILL_RANDOM);
    msg = msg[0:7];
    queue_message(1);
    wait_idle();

    write_xid(32'hFFFF_FFFF);
    for (int i = 0; i < 4; i++) begin
      put_header(BOOTREPLY, xid_model ^ (32'h0000_0001 << (8*i)), 0, FILL_RANDOM);
      msg = msg[0:7];
      queue_message(1);
    end
    wait_idle();

    write_xid($urandom);
    put_header(BOOTREPLY, xid_model, 5, FILL_RANDOM);
    put_cookie(0);
    put_option(TAG_MASK, 4, FILL_RANDOM);
    queue_message(1);

    // The sender holds off in the middle of a reply until the record stream drains.
    put_header(BOOTREPLY, xid_model, 128, FILL_ONES);
    put_cookie(1);
    queue_message(0);
    wait_idle();
    idle_pct = 0;
    msg.push_back(TAG_PAD);
    put_option(TAG_MASK, 4, FILL_RANDOM);
    put_option(TAG_MASK, 5, FILL_RANDOM);
    put_option(TAG_MASK, 3, FILL_RANDOM);
    put_option(TAG_TOFFS, 4, FILL_RANDOM);
    put_option(TAG_TOFFS, 3, FILL_RANDOM);
    put_option(TAG_ROUTER, 8, FILL_RANDOM);
    put_option(TAG_TSRV, 4, FILL_ONES);
    put_option(TAG_DNS, 12, FILL_RANDOM);
    put_option(TAG_LOG, 4, FILL_ZERO);
    put_option(TAG_LPR, 5, FILL_RANDOM);
    put_option(TAG_SWAP, 4, FILL_RANDOM);
    put_option(TAG_BSIZE, 2, FILL_ONES);
    put_option(TAG_BSIZE, 3, FILL_RANDOM);
    put_option(TAG_BSIZE, 2, FILL_RANDOM);
    put_option(TAG_HOST, 70, FILL_TEXT);
    put_option(TAG_DOMAIN, 12, FILL_TEXT);
    msg[msg.size()-6] = 8'h00;
    put_option(TAG_UNKNOWN_A, 0, FILL_RANDOM);
    put_option(TAG_UNKNOWN_B, 3, FILL_RANDOM);
    msg.push_back(TAG_END);
    repeat (5) msg.push_back(fill_byte(FILL_RANDOM));
    queue_message(1);
    put_header(BOOTREPLY, xid_model, 20, FILL_RANDOM);
    put_cookie(1);
    put_option(TAG_DNS, 4, FILL_RANDOM);
    put_option(TAG_ROUTER, 8, FILL_RANDOM);
    msg = msg[0 : msg.size() - 6];
    queue_message(1);
    wait_idle();
    idle_pct = 11;
    repeat (8) @(posedge clk);

    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
